// File: rtl/srld_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srld_pkg: shared constants for the sensor reading to LED digits unit
// Scale factors, rounding and saturation limits, display codes and addresses.
// ----------------------------------------------------------------------------
package srld_pkg;

	localparam int unsigned WRITES_PER_READING = 7;
	localparam int unsigned POS_W = 3;

	// micro-unit scaling
	localparam logic [7:0]  TEMP_SCALE   = 8'd191;
	localparam logic [7:0]  HUMID_SCALE  = 8'd95;
	localparam logic [27:0] TEMP_OFFSET  = 28'd50000000;
	localparam logic [27:0] HALF_TENTH   = 28'd50000;
	// magnitude at or above this rounds past 99.9
	localparam logic [27:0] SAT_LIMIT    = 28'd99950000;

	// floor(y / 3125) = (y * RECIP) >> RECIP_SHIFT, exact for y < 2**22
	localparam logic [22:0] RECIP        = 23'd5497559;
	localparam int unsigned RECIP_SHIFT  = 34;
	localparam logic [9:0]  TENTHS_MAX   = 10'd999;

	// display codes
	localparam logic [7:0]  SIGN_MINUS   = 8'h0A;
	localparam logic [7:0]  SIGN_BLANK   = 8'h0F;
	localparam logic [7:0]  POINT_BIT    = 8'h80;

	// display register addresses
	localparam logic [3:0]  REG_SIGN     = 4'd8;
	localparam logic [3:0]  REG_TEMP_TOP = 4'd7;
	localparam logic [3:0]  REG_HUM_TOP  = 4'd3;

	typedef struct packed {
		logic [3:0] dreg;
		logic [7:0] code;
	} digit_write_t;

endpackage

// File: rtl/sensor_reading_to_led_digits_unit.sv
`timescale 1ns / 1ps
// Path: a reading passes the stage 1 to 4 registers and the output buffer.
// Throughput: seven serial display writes leave the output buffer one per cycle
//   while m_tready is high; the four pipeline stages take a new reading every
//   cycle unless stalled; a full stage holds its data until the next takes it.
// Reset: arst_n clears all valid bits and the write position; data registers
//   are not reset.
// ----------------------------------------------------------------------------
// sensor_reading_to_led_digits_unit: reading bytes to seven-segment writes
// Unpacks humidity and temperature codes, scales to micro-units, rounds to
// tenths with saturation at 99.9 and emits seven display register writes.
// ----------------------------------------------------------------------------
module sensor_reading_to_led_digits_unit (
	input  logic        clk,
	input  logic        arst_n,
	// slave side: tdata = humid_high_byte[7:0], humid_mid_byte[15:8],
	//   shared_byte[23:16], temp_mid_byte[31:24], temp_low_byte[39:32]
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,
	// master side: tdata = digit_register[3:0], digit_code[11:4], zeros above
	//   tlast = last_write
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,
	output logic        m_tlast
);
	import srld_pkg::*;

	// ------------------------------------------------------------------
	// Stage 1: unpack the codes and scale them to micro-units
	// ------------------------------------------------------------------
	logic [19:0] humid_code;
	logic [19:0] temp_code;
	logic        valid_s1;
	logic [27:0] temp_scaled_s1;
	logic [26:0] humid_scaled_s1;
	logic        ready_s1;

	// ------------------------------------------------------------------
	// Stage 2: magnitude, saturation check, rounding offset, divide by 32
	// ------------------------------------------------------------------
	logic        temp_neg;
	logic [27:0] temp_mag;
	logic [27:0] temp_sum;
	logic [27:0] humid_mag;
	logic [27:0] humid_sum;
	logic        valid_s2;
	logic        neg_s2;
	logic        temp_sat_s2;
	logic        humid_sat_s2;
	logic [21:0] temp_y_s2;
	logic [21:0] humid_y_s2;
	logic        ready_s2;

	// ------------------------------------------------------------------
	// Stage 3: divide by 3125 through a reciprocal multiply -> tenths
	// ------------------------------------------------------------------
	logic [44:0] temp_prod;
	logic [44:0] humid_prod;
	logic        valid_s3;
	logic        neg_s3;
	logic [9:0]  temp_q_s3;
	logic [9:0]  humid_q_s3;
	logic        ready_s3;

	// ------------------------------------------------------------------
	// Stage 4: split off the tens digit, keep the remainder 0..99
	// ------------------------------------------------------------------
	logic [15:0] temp_h_prod;
	logic [15:0] humid_h_prod;
	logic [3:0]  temp_hund;
	logic [3:0]  humid_hund;
	logic        valid_s4;
	logic        neg_s4;
	logic [3:0]  temp_tens_s4;
	logic [3:0]  humid_tens_s4;
	logic [6:0]  temp_rem_s4;
	logic [6:0]  humid_rem_s4;
	logic        ready_s4;

	// ------------------------------------------------------------------
	// Output buffer: units and tenths, seven writes sent, while m_tready is high, one per cycle
	// ------------------------------------------------------------------
	logic [14:0]  temp_u_prod;
	logic [14:0]  humid_u_prod;
	logic [3:0]   temp_units;
	logic [3:0]   humid_units;
	logic [3:0]   temp_tenths;
	logic [3:0]   humid_tenths;
	logic         last_pos;
	logic         buf_load;
	logic         busy_q;
	logic [POS_W-1:0] write_position_q;
	digit_write_t pending_writes_q [WRITES_PER_READING];
	digit_write_t new_writes [WRITES_PER_READING];
	digit_write_t cur_write;

	// elastic pipeline: a stage takes new data when empty or when it moves on
	assign last_pos = (write_position_q == POS_W'(WRITES_PER_READING - 1));
	assign ready_s4 = !busy_q || (m_tready && last_pos);
	assign ready_s3 = !valid_s4 || ready_s4;
	assign ready_s2 = !valid_s3 || ready_s3;
	assign ready_s1 = !valid_s2 || ready_s2;
	assign s_tready = !valid_s1 || ready_s1;
	assign buf_load = valid_s4 && ready_s4;

	// stage 1
	assign humid_code = {s_tdata[7:0], s_tdata[15:8], s_tdata[23:20]};
	assign temp_code  = {s_tdata[19:16], s_tdata[31:24], s_tdata[39:32]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			temp_scaled_s1  <= 28'(temp_code) * 28'(TEMP_SCALE);
			humid_scaled_s1 <= 27'(humid_code) * 27'(HUMID_SCALE);
		end
	end

	// stage 2
	assign temp_neg  = (temp_scaled_s1 < TEMP_OFFSET);
	assign temp_mag  = temp_neg ? (TEMP_OFFSET - temp_scaled_s1)
	                            : (temp_scaled_s1 - TEMP_OFFSET);
	assign temp_sum  = temp_mag + HALF_TENTH;
	assign humid_mag = {1'b0, humid_scaled_s1};
	assign humid_sum = humid_mag + HALF_TENTH;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	// low five bits drop: /100000 = (/32) then (/3125)
	always_ff @(posedge clk) begin
		if (ready_s1 && valid_s1) begin
			neg_s2       <= temp_neg;
			temp_sat_s2  <= (temp_mag >= SAT_LIMIT);
			humid_sat_s2 <= (humid_mag >= SAT_LIMIT);
			temp_y_s2    <= temp_sum[26:5];
			humid_y_s2   <= humid_sum[26:5];
		end
	end

	// stage 3
	assign temp_prod  = 45'(temp_y_s2) * 45'(RECIP);
	assign humid_prod = 45'(humid_y_s2) * 45'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s2) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s2) begin
			neg_s3     <= neg_s2;
			temp_q_s3  <= temp_sat_s2 ? TENTHS_MAX
			                          : temp_prod[RECIP_SHIFT +: 10];
			humid_q_s3 <= humid_sat_s2 ? TENTHS_MAX
			                           : humid_prod[RECIP_SHIFT +: 10];
		end
	end

	// stage 4: q / 100 = (q * 41) >> 12 for q < 1000
	assign temp_h_prod  = 16'(temp_q_s3) * 16'd41;
	assign humid_h_prod = 16'(humid_q_s3) * 16'd41;
	assign temp_hund    = temp_h_prod[15:12];
	assign humid_hund   = humid_h_prod[15:12];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (ready_s3) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s3) begin
			neg_s4        <= neg_s3;
			temp_tens_s4  <= temp_hund;
			humid_tens_s4 <= humid_hund;
			temp_rem_s4   <= 7'(temp_q_s3 - 10'(temp_hund) * 10'd100);
			humid_rem_s4  <= 7'(humid_q_s3 - 10'(humid_hund) * 10'd100);
		end
	end

	// units and tenths: r / 10 = (r * 205) >> 11 for r < 100
	assign temp_u_prod  = 15'(temp_rem_s4) * 15'd205;
	assign humid_u_prod = 15'(humid_rem_s4) * 15'd205;
	assign temp_units   = temp_u_prod[14:11];
	assign humid_units  = humid_u_prod[14:11];
	assign temp_tenths  = 4'(temp_rem_s4 - 7'(temp_units) * 7'd10);
	assign humid_tenths = 4'(humid_rem_s4 - 7'(humid_units) * 7'd10);

	always_comb begin
		new_writes[0] = '{dreg: REG_SIGN, code: (neg_s4 ? SIGN_MINUS : SIGN_BLANK)};
		new_writes[1] = '{dreg: REG_TEMP_TOP, code: 8'(temp_tens_s4)};
		new_writes[2] = '{dreg: REG_TEMP_TOP - 4'd1, code: 8'(temp_units) | POINT_BIT};
		new_writes[3] = '{dreg: REG_TEMP_TOP - 4'd2, code: 8'(temp_tenths)};
		new_writes[4] = '{dreg: REG_HUM_TOP, code: 8'(humid_tens_s4)};
		new_writes[5] = '{dreg: REG_HUM_TOP - 4'd1, code: 8'(humid_units) | POINT_BIT};
		new_writes[6] = '{dreg: REG_HUM_TOP - 4'd2, code: 8'(humid_tenths)};
	end

	// buffer control: busy while writes are pending, position walks 0..6
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q           <= 1'b0;
			write_position_q <= '0;
		end else if (buf_load) begin
			busy_q           <= 1'b1;
			write_position_q <= '0;
		end else if (busy_q && m_tready) begin
			if (last_pos) begin
				busy_q           <= 1'b0;
				write_position_q <= '0;
			end else begin
				write_position_q <= write_position_q + POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (buf_load) begin
			for (int i = 0; i < WRITES_PER_READING; i++) begin
				pending_writes_q[i] <= new_writes[i];
			end
		end
	end

	// output transaction
	assign cur_write = pending_writes_q[write_position_q];
	assign m_tvalid  = busy_q;
	assign m_tdata   = {4'b0000, cur_write.code, cur_write.dreg};
	assign m_tlast   = last_pos;

endmodule
